[src/depq_pkg.sv]
package depq_pkg;

  localparam int VAL_W        = 32;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 8;
  localparam int CAPACITY_DEF = 128;
  localparam int GROUP_DEF    = 16;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL_MIN = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL_MAX = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  // Command broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic ins;
    logic del_min;
    logic del_max;
    val_t v;
  } cmd_t;

  // What a cell shows to its right-hand neighbor.
  typedef struct packed {
    logic lt;
    logic vld;
    val_t val;
  } link_t;

endpackage

[src/depq_cell.sv]
module depq_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  depq_pkg::cmd_t       cmd,
  input  depq_pkg::link_t      left,
  input  logic                 right_vld,
  input  depq_pkg::val_t       right_val,
  output depq_pkg::link_t      self,
  output depq_pkg::val_t       top_val
);

  logic           vld_r, vld_nxt;
  depq_pkg::val_t val_r, val_nxt;
  logic           lt;
  logic           is_top;

  // Chain is kept ascending; empty cells count as larger than anything.
  assign lt     = !vld_r || (cmd.v < val_r);
  assign is_top = vld_r && !right_vld;

  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    if (cmd.ins && lt) begin
      if (left.lt) begin
        // shift up: take the left neighbor's word
        vld_nxt = left.vld;
        val_nxt = left.val;
      end else begin
        vld_nxt = 1'b1;
        val_nxt = cmd.v;
      end
    end else if (cmd.del_min) begin
      vld_nxt = right_vld;
      val_nxt = right_val;
    end else if (cmd.del_max && is_top) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign self    = '{lt: lt, vld: vld_r, val: val_r};
  assign top_val = is_top ? val_r : '0;

endmodule

[src/depq_grp.sv]
module depq_grp #(
  parameter int N = depq_pkg::GROUP_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [N-1:0][depq_pkg::VAL_W-1:0] din,
  output logic [depq_pkg::VAL_W-1:0]    dout
);

  logic [depq_pkg::VAL_W-1:0] acc;
  logic [depq_pkg::VAL_W-1:0] or_r;

  // At most one input is nonzero, so an OR picks it out.
  always_comb begin
    acc = '0;
    for (int i = 0; i < N; i++) begin
      acc = acc | din[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      or_r <= acc;
    end
  end

  assign dout = or_r;

endmodule

[src/double_ended_priority_queue.sv]
// Double-ended priority queue of signed 32-bit words, up to CAPACITY deep.
// Each request word carries an op (insert, delete-min, delete-max) and a
// value; each answers with exactly one result word: the removed value
// (zero for inserts and failures), a status (ok, overflow on a full
// insert, underflow on an empty delete) and the count after the request,
// truncated to 8 bits. A failing request leaves the contents unchanged;
// op code three is a no-op that reports ok. Storage is a chain of cells
// kept in ascending order: an insert slots in by a compare in every cell
// and a one-place shift up, delete-min shifts the whole chain down one
// place, delete-max clears the topmost valid cell. Insert and delete-min
// are taken back to back unless the receiver stalls. Delete-max is not:
// the removed value is gathered from the cells through a two-level OR tree
// (groups of GROUP cells, registered, then one OR across the groups), and
// the block holds in_stall until it reaches the output register. The result
// sits in an output register, so a new request can be taken in the same
// cycle the previous result leaves. There is no clearing pass after reset.
module double_ended_priority_queue #(
  parameter int CAPACITY = depq_pkg::CAPACITY_DEF,
  parameter int GROUP    = depq_pkg::GROUP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [depq_pkg::OP_W-1:0]        in_op,
  input  logic signed [depq_pkg::VAL_W-1:0] in_value_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [depq_pkg::VAL_W-1:0] out_value_out,
  output logic [depq_pkg::STATUS_W-1:0]    out_status,
  output logic [depq_pkg::COUNT_W-1:0]     out_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;
  localparam int NPAD  = NGRP * GROUP;
  localparam int VW    = depq_pkg::VAL_W;

  // Chain wiring
  depq_pkg::cmd_t  cmd;
  depq_pkg::link_t links [CAPACITY];
  depq_pkg::link_t lefts [CAPACITY];
  logic [CAPACITY-1:0] vld_vec;
  logic [NPAD-1:0][VW-1:0] top_vals;
  logic [NGRP-1:0][VW-1:0] grp_or;

  // Control
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pend_r;
  logic             acc;
  logic             full, empty;
  logic             is_ins, is_dmin, is_dmax;
  logic [depq_pkg::STATUS_W-1:0] status;
  logic [VW-1:0]    max_val;

  // Output register
  logic                          out_valid_r;
  logic signed [VW-1:0]          out_value_r;
  logic [depq_pkg::STATUS_W-1:0] out_status_r;
  logic [depq_pkg::COUNT_W-1:0]  out_count_r;

  // Hold requests while the output word waits or a delete-max finishes.
  assign in_stall = pend_r || (out_valid_r && out_stall);
  assign acc      = in_valid && !in_stall;

  assign full    = (count_r == CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);
  assign is_ins  = (in_op == depq_pkg::OP_INSERT);
  assign is_dmin = (in_op == depq_pkg::OP_DEL_MIN);
  assign is_dmax = (in_op == depq_pkg::OP_DEL_MAX);

  always_comb begin
    status = depq_pkg::ST_OK;
    if (is_ins && full) begin
      status = depq_pkg::ST_OVERFLOW;
    end else if ((is_dmin || is_dmax) && empty) begin
      status = depq_pkg::ST_UNDERFLOW;
    end
  end

  // Only successful operations reach the cells.
  assign cmd = '{ins:     acc && is_ins && !full,
                 del_min: acc && is_dmin && !empty,
                 del_max: acc && is_dmax && !empty,
                 v:       in_value_in};

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del_min || cmd.del_max) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Cell chain: cell 0 holds the minimum.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{lt: 1'b0, vld: 1'b1, val: '0};
    end else begin : g_mid
      assign lefts[i] = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      depq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .left      (lefts[i]),
        .right_vld (1'b0),
        .right_val ('0),
        .self      (links[i]),
        .top_val   (top_vals[i])
      );
    end else begin : g_inner
      depq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .left      (lefts[i]),
        .right_vld (links[i+1].vld),
        .right_val (links[i+1].val),
        .self      (links[i]),
        .top_val   (top_vals[i])
      );
    end

    assign vld_vec[i] = links[i].vld;
  end

  for (genvar i = CAPACITY; i < NPAD; i++) begin : g_pad
    assign top_vals[i] = '0;
  end

  // First level of the max gather: one registered OR per group.
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    depq_grp #(
      .N (GROUP)
    ) u_grp (
      .clk  (clk),
      .load (acc),
      .din  (top_vals[g*GROUP +: GROUP]),
      .dout (grp_or[g])
    );
  end

  always_comb begin
    max_val = '0;
    for (int g = 0; g < NGRP; g++) begin
      max_val = max_val | grp_or[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        // delete-max waits in pend_r while the group ORs are registered
        pend_r      <= cmd.del_max;
        out_valid_r <= !cmd.del_max;
      end else if (pend_r) begin
        pend_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status_r <= status;
      out_count_r  <= depq_pkg::COUNT_W'(count_nxt);
      out_value_r  <= cmd.del_min ? links[0].val : '0;
    end else if (pend_r) begin
      out_value_r <= max_val;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;

  // Valid cells form a run from cell 0; the check is that their number matches the count.
  a_vld_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(count_r))
    else $error("cell valid bits disagree with count");

  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_pend_out : assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid_r && !pend_r)
    else $error("delete-max result not delivered");

  a_min_order : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > CNT_W'(1)) |-> (links[0].val <= links[1].val))
    else $error("chain out of order at the low end");

endmodule

[test/tb.sv]
module tb;

  localparam int CLK_HALF    = 5;
  localparam int CAPACITY    = depq_pkg::CAPACITY_DEF;
  localparam int RUN_LIMIT   = 200000;  // cycles before the run is declared hung
  localparam int HOLD_CYCLES = 400;     // length of the long receiver hold-off
  localparam int END_SLACK   = 16;      // quiet cycles after the last result
  localparam int IDLE_PCT    = 31;

  // Op code three is not in the package; the block treats it as a no-op.
  localparam logic [depq_pkg::OP_W-1:0] OP_NOP = 2'd3;

  typedef struct packed {
    depq_pkg::val_t                value;
    logic [depq_pkg::STATUS_W-1:0] status;
    logic [depq_pkg::COUNT_W-1:0]  count;
  } depq_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [depq_pkg::OP_W-1:0]     in_op = '0;
  depq_pkg::val_t                in_value_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  depq_pkg::val_t                out_value_out;
  logic [depq_pkg::STATUS_W-1:0] out_status;
  logic [depq_pkg::COUNT_W-1:0]  out_count;

  // Shadow of the queue contents, in arrival order, and the results still owed.
  depq_pkg::val_t shadow_entries[$];
  depq_result_t   pending_results[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  bit  in_gaps_on = 1'b1;
  bit  out_gaps_on = 1'b1;
  int  hold_request = 0;
  int  hold_served = 0;
  int  hold_left = 0;

  double_ended_priority_queue dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_value_in  (in_value_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value_out(out_value_out),
    .out_status   (out_status),
    .out_count    (out_count)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Apply one request word to the shadow queue and return the word the block
  // must answer with. Among equal extremes the lowest position goes first.
  function automatic depq_result_t apply_request(input logic [depq_pkg::OP_W-1:0] op,
                                                 input depq_pkg::val_t v);
    depq_result_t r;
    int pos;
    int i;
    r.value  = '0;
    r.status = depq_pkg::ST_OK;
    case (op)
      depq_pkg::OP_INSERT: begin
        if (shadow_entries.size() >= CAPACITY) r.status = depq_pkg::ST_OVERFLOW;
        else shadow_entries.push_back(v);
      end
      depq_pkg::OP_DEL_MIN, depq_pkg::OP_DEL_MAX: begin
        if (shadow_entries.size() == 0) begin
          r.status = depq_pkg::ST_UNDERFLOW;
        end else begin
          pos = 0;
          for (i = 1; i < shadow_entries.size(); i++) begin
            if (op == depq_pkg::OP_DEL_MAX ? shadow_entries[i] > shadow_entries[pos]
                                           : shadow_entries[i] < shadow_entries[pos])
              pos = i;
          end
          r.value = shadow_entries[pos];
          shadow_entries.delete(pos);
        end
      end
      default: ;  // no-op: report ok with the current count
    endcase
    r.count = depq_pkg::COUNT_W'(shadow_entries.size());
    return r;
  endfunction

  // Random value: half full-range, with extremes and a narrow band that
  // makes ties common.
  function automatic depq_pkg::val_t pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3, 4: return depq_pkg::val_t'($urandom_range(16)) - 8;
      default: return depq_pkg::val_t'($urandom);
    endcase
  endfunction

  // Pick one of the two deletes at random.
  function automatic logic [depq_pkg::OP_W-1:0] pick_delete();
    return $urandom_range(1) ? depq_pkg::OP_DEL_MAX : depq_pkg::OP_DEL_MIN;
  endfunction

  // Offer one request word, idling first at random, and hold it until taken.
  // Valid is only lowered on idle cycles, so it never drops and rises in one step.
  task automatic send_request(input logic [depq_pkg::OP_W-1:0] op, input depq_pkg::val_t v);
    while (in_gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_value_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_request(op, v));
  endtask

  // Drop valid and hold until every owed result word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Empty queue, no-op, extremes of the value field, ties, then empty again.
  task automatic test_directed();
    send_request(depq_pkg::OP_DEL_MIN, depq_pkg::val_t'($urandom));
    send_request(depq_pkg::OP_DEL_MAX, 32'sh7fff_ffff);
    send_request(OP_NOP, depq_pkg::val_t'($urandom));
    send_request(depq_pkg::OP_INSERT, 32'sh7fff_ffff);
    send_request(depq_pkg::OP_INSERT, 32'sh8000_0000);
    send_request(depq_pkg::OP_INSERT, 0);
    send_request(depq_pkg::OP_INSERT, -1);
    send_request(depq_pkg::OP_INSERT, 1);
    send_request(OP_NOP, 32'sh8000_0000);
    send_request(depq_pkg::OP_DEL_MAX, depq_pkg::val_t'($urandom));
    send_request(depq_pkg::OP_DEL_MIN, depq_pkg::val_t'($urandom));
    send_request(depq_pkg::OP_INSERT, 7);
    send_request(depq_pkg::OP_INSERT, 7);
    send_request(depq_pkg::OP_INSERT, -3);
    send_request(depq_pkg::OP_INSERT, -3);
    send_request(depq_pkg::OP_DEL_MAX, 0);
    send_request(depq_pkg::OP_DEL_MIN, 0);
    send_request(depq_pkg::OP_DEL_MIN, -1);
    send_request(depq_pkg::OP_DEL_MAX, -1);
    while (shadow_entries.size() != 0)
      send_request(pick_delete(), depq_pkg::val_t'($urandom));
    send_request(depq_pkg::OP_DEL_MAX, 0);
  endtask

  // Fill to capacity, push past it, then empty it and push past that.
  task automatic test_fill_and_overflow();
    while (shadow_entries.size() < CAPACITY) send_request(depq_pkg::OP_INSERT, pick_value());
    send_request(depq_pkg::OP_INSERT, pick_value());
    send_request(depq_pkg::OP_INSERT, 32'sh8000_0000);
    send_request(OP_NOP, pick_value());
    send_request(depq_pkg::OP_DEL_MAX, pick_value());
    send_request(depq_pkg::OP_INSERT, pick_value());
    send_request(depq_pkg::OP_INSERT, pick_value());
    while (shadow_entries.size() != 0)
      send_request(pick_delete(), pick_value());
    send_request(depq_pkg::OP_DEL_MIN, pick_value());
    send_request(depq_pkg::OP_DEL_MAX, pick_value());
  endtask

  // Random mix; insert_pct steers the fill level up or down.
  task automatic test_random_mix(input int n_words, input int insert_pct);
    int r;
    repeat (n_words) begin
      r = $urandom_range(99);
      if (r < 3) send_request(OP_NOP, pick_value());
      else if (r < 3 + insert_pct) send_request(depq_pkg::OP_INSERT, pick_value());
      else send_request(pick_delete(), pick_value());
    end
  endtask

  // Stall the result side for a long stretch while words keep coming, so the
  // block backs up into in_stall; then pause the sender until fully drained.
  task automatic test_backpressure();
    in_gaps_on = 1'b0;
    hold_request++;
    test_random_mix(60, 60);
    in_gaps_on = 1'b1;
    wait_drained();
  endtask

  // Receiver: random stalls, plus the long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request != hold_served) begin
      hold_served <= hold_request;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= out_gaps_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Check each accepted result word against the oldest owed one.
  always @(posedge clk) begin
    depq_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing owed: value_out %0d status %0d count %0d",
               out_value_out, out_status, out_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_value_out !== want.value) begin
          $error("value_out: expected %0d, got %0d", want.value, out_value_out);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("double_ended_priority_queue verification failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_overflow();
    test_backpressure();

    // Grow toward full, drain toward empty, and one stretch with no idling.
    test_random_mix(150, 75);
    test_random_mix(100, 25);
    wait_drained();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    test_random_mix(150, 80);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    test_random_mix(120, 20);
    test_random_mix(90, 50);

    wait_drained();
    repeat (END_SLACK) @(posedge clk);
    if (fail_count == 0) $display("double_ended_priority_queue verification clean");
    else $display("double_ended_priority_queue verification failed");
    $finish;
  end

endmodule

[filelist.f]
src/depq_pkg.sv
src/depq_cell.sv
src/depq_grp.sv
src/double_ended_priority_queue.sv
test/tb.sv
